### rtl/romt_pkg.sv
// package for the recency ordered message table
// constants, request codes, controller/datapath command and status types
package romt_pkg;

  localparam int unsigned MaxEntries = 8;
  localparam logic [7:0] HourLast = 8'd23;
  localparam logic [7:0] MinuteLast = 8'd59;

  localparam logic [2:0] ReqUpsert = 3'd0;
  localparam logic [2:0] ReqRemove = 3'd1;
  localparam logic [2:0] ReqMarkRead = 3'd2;
  localparam logic [2:0] ReqClear = 3'd3;
  localparam logic [2:0] ReqPreview = 3'd4;
  localparam logic [2:0] ReqLookup = 3'd5;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StInvalid = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;

  localparam logic [2:0] CfgDnd = 3'd0;
  localparam logic [2:0] CfgAppMin = 3'd1;
  localparam logic [2:0] CfgAppMax = 3'd2;
  localparam logic [2:0] CfgTitleLim = 3'd3;
  localparam logic [2:0] CfgBodyLim = 3'd4;

  typedef struct packed {
    logic       load;     // capture input item
    logic       scan;     // compare one slot, advance pointer
    logic       shift;    // move slot ptr+1 into ptr, advance
    logic       write;    // write new entry at ptr
    logic       clr_unread; // clear unread at found slot
    logic       clear_all;
    logic       dec_fill;
    logic       inc_fill;
    logic       bump_rev;
    logic       take_prev;
    logic       set_prev;
    logic       drop_prev;  // clear pending if it equals id
    logic       start_cnt;  // restart unread count sweep
    logic       cnt;        // count one slot
    logic       capture;    // write result register
    logic [1:0] status;
    logic       alert;
    logic       lookup;
    logic       ptr_zero;
    logic       ptr_found;
    logic       ptr_last;   // ptr = fill-1
  } romt_cmd_t;

  typedef struct packed {
    logic req_ok;     // upsert fields valid
    logic id_zero;
    logic hit;        // slot ptr matches id
    logic scan_end;   // ptr >= fill-1
    logic at_end;     // ptr+1 >= fill
    logic same;       // found slot holds same app, lengths, tag
    logic found_unread;
    logic full;
    logic empty;
    logic pend_match;
    logic cnt_end;
    logic dnd;
  } romt_sts_t;

endpackage

### rtl/romt_datapath.sv
// datapath: slot store, pointer, counters, config registers and result register
// depends on romt_pkg
module romt_datapath #(
  parameter int unsigned MaxEntries = romt_pkg::MaxEntries
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic [111:0]        in_data_i,
  input  romt_pkg::romt_cmd_t cmd_i,
  output romt_pkg::romt_sts_t sts_o,
  output logic [2:0]          req_o,
  output logic [111:0]        res_o
);
  localparam int unsigned PW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CW = $clog2(MaxEntries + 1);

  logic [15:0] key_q [MaxEntries];
  logic [7:0]  app_q [MaxEntries];
  logic [10:0] tim_q [MaxEntries];
  logic        unr_q [MaxEntries];
  logic [31:0] len_q [MaxEntries];
  logic [31:0] tag_q [MaxEntries];

  logic [2:0]  req_q;
  logic [15:0] id_q;
  logic [7:0]  app_in_q, hr_q, mn_q;
  logic [15:0] tl_q, bl_q;
  logic [31:0] tg_q;

  logic [CW-1:0] fill_q, cnt_q, cnt_d;
  logic [PW-1:0] ptr_q, fnd_q;
  logic [31:0] rev_q;
  logic [15:0] prev_q;
  logic        dnd_q;
  logic [7:0]  amin_q, amax_q;
  logic [15:0] tlim_q, blim_q;
  logic [111:0] res_q, res_d;
  logic [15:0] pv_q;

  logic [PW-1:0] ptr_n;
  logic [CW-1:0] ptr_w;
  assign ptr_w = CW'(ptr_q);
  assign ptr_n = (MaxEntries > 1) ? PW'(ptr_q + 1'b1) : '0;

  assign req_o = req_q;

  always_comb begin
    sts_o.req_ok = (id_q != '0) && (app_in_q >= amin_q) && (app_in_q <= amax_q) &&
                   (hr_q <= romt_pkg::HourLast) && (mn_q <= romt_pkg::MinuteLast) &&
                   (tl_q <= tlim_q) && (bl_q <= blim_q);
    sts_o.id_zero = (id_q == '0);
    sts_o.hit = (ptr_w < fill_q) && (key_q[ptr_q] == id_q);
    sts_o.scan_end = (ptr_w + 1'b1 >= fill_q);
    sts_o.at_end = (ptr_w + 1'b1 >= fill_q);
    sts_o.same = (app_q[fnd_q] == app_in_q) && (len_q[fnd_q] == {tl_q, bl_q}) &&
                 (tag_q[fnd_q] == tg_q);
    sts_o.found_unread = unr_q[fnd_q];
    sts_o.full = (fill_q == CW'(MaxEntries));
    sts_o.empty = (fill_q == '0);
    sts_o.pend_match = (prev_q == id_q);
    sts_o.cnt_end = sts_o.scan_end;
    sts_o.dnd = dnd_q;
  end

  // slot store and input item registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift && ptr_n != ptr_q) begin
      key_q[ptr_q] <= key_q[ptr_n];
      app_q[ptr_q] <= app_q[ptr_n];
      tim_q[ptr_q] <= tim_q[ptr_n];
      unr_q[ptr_q] <= unr_q[ptr_n];
      len_q[ptr_q] <= len_q[ptr_n];
      tag_q[ptr_q] <= tag_q[ptr_n];
    end
    if (cmd_i.write) begin
      key_q[ptr_q] <= id_q;
      app_q[ptr_q] <= app_in_q;
      tim_q[ptr_q] <= {hr_q[4:0], mn_q[5:0]};
      unr_q[ptr_q] <= 1'b1;
      len_q[ptr_q] <= {tl_q, bl_q};
      tag_q[ptr_q] <= tg_q;
    end
    if (cmd_i.clr_unread) unr_q[fnd_q] <= 1'b0;
    if (cmd_i.load) begin
      req_q <= in_data_i[2:0];
      id_q <= in_data_i[18:3];
      app_in_q <= in_data_i[26:19];
      hr_q <= in_data_i[34:27];
      mn_q <= in_data_i[42:35];
      tl_q <= in_data_i[58:43];
      bl_q <= in_data_i[74:59];
      tg_q <= in_data_i[106:75];
    end
  end

  // running unread count, including the slot counted this cycle
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.start_cnt) cnt_d = '0;
    else if (cmd_i.cnt && ptr_w < fill_q) cnt_d = cnt_q + CW'(unr_q[ptr_q]);
  end

  always_comb begin
    res_d = '0;
    res_d[1:0] = cmd_i.status;
    res_d[2] = cmd_i.alert;
    res_d[6:3] = 4'(fill_q);
    res_d[10:7] = 4'(cnt_d);
    res_d[42:11] = rev_q;
    res_d[58:43] = pv_q;
    if (cmd_i.lookup) begin
      res_d[66:59] = app_q[fnd_q];
      res_d[71:67] = tim_q[fnd_q][10:6];
      res_d[77:72] = tim_q[fnd_q][5:0];
      res_d[78] = unr_q[fnd_q];
      res_d[94:79] = len_q[fnd_q][31:16];
      res_d[110:95] = len_q[fnd_q][15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q <= '0;
      ptr_q <= '0;
      fnd_q <= '0;
      rev_q <= '0;
      prev_q <= '0;
      pv_q <= '0;
      dnd_q <= 1'b0;
      amin_q <= 8'd0;
      amax_q <= 8'd15;
      tlim_q <= 16'd64;
      blim_q <= 16'd256;
      res_q <= '0;
    end else begin
      if (cmd_i.ptr_zero) ptr_q <= '0;
      // a hit on the last scanned slot is not in fnd_q yet
      else if (cmd_i.ptr_found) ptr_q <= (cmd_i.scan && sts_o.hit) ? ptr_q : fnd_q;
      else if (cmd_i.ptr_last) ptr_q <= PW'(fill_q - 1'b1);
      else if (cmd_i.scan || cmd_i.shift || cmd_i.cnt) ptr_q <= ptr_n;
      if (cmd_i.scan && sts_o.hit) fnd_q <= ptr_q;
      if (cmd_i.clear_all) fill_q <= '0;
      else if (cmd_i.dec_fill) fill_q <= fill_q - 1'b1;
      else if (cmd_i.inc_fill) fill_q <= fill_q + 1'b1;
      if (cmd_i.bump_rev) rev_q <= rev_q + 1'b1;
      if (cmd_i.load) pv_q <= '0;
      else if (cmd_i.take_prev) pv_q <= prev_q;
      if (cmd_i.take_prev || cmd_i.clear_all) prev_q <= '0;
      else if (cmd_i.set_prev) prev_q <= id_q;
      else if (cmd_i.drop_prev && prev_q == id_q) prev_q <= '0;
      cnt_q <= cnt_d;
      if (cmd_i.capture) res_q <= res_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          romt_pkg::CfgDnd: begin
            dnd_q <= cfg_data_i[0];
            if (cfg_data_i[0]) prev_q <= '0;
          end
          romt_pkg::CfgAppMin: amin_q <= cfg_data_i[7:0];
          romt_pkg::CfgAppMax: amax_q <= cfg_data_i[7:0];
          romt_pkg::CfgTitleLim: tlim_q <= cfg_data_i;
          romt_pkg::CfgBodyLim: blim_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign res_o = res_q;
endmodule

### rtl/romt_ctrl.sv
// controller: sequences search, shift, write, unread count and result
// depends on romt_pkg
module romt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  logic [2:0]          req_i,
  input  romt_pkg::romt_sts_t sts_i,
  output romt_pkg::romt_cmd_t cmd_o
);
  typedef enum logic [2:0] {
    Idle, Decode, Search, Shift, Write, CntStart, Count, Done
  } state_e;

  state_e state_q;
  logic found_q, mov_q;
  logic [1:0] st_q;
  logic al_q, lk_q, out_v_q;

  assign in_ready_o = (state_q == Idle);
  assign out_valid_o = out_v_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.status = st_q;
    cmd_o.alert = al_q;
    cmd_o.lookup = lk_q;
    case (state_q)
      Idle: begin
        cmd_o.load = in_valid_i;
        cmd_o.ptr_zero = 1'b1;
      end
      Decode: ;
      Search: cmd_o.scan = 1'b1;
      // an unchanged upsert must leave the found slot in place
      Shift: cmd_o.shift = !sts_i.at_end &&
                           !(req_i == romt_pkg::ReqUpsert && !mov_q && found_q && sts_i.same);
      Write: cmd_o.write = 1'b1;
      CntStart: begin
        cmd_o.start_cnt = 1'b1;
        cmd_o.ptr_zero = 1'b1;
      end
      Count: begin
        cmd_o.cnt = 1'b1;
        cmd_o.capture = sts_i.cnt_end;
      end
      Done: ;
      default: ;
    endcase
    // one-shot actions at the end of search
    if (state_q == Search && sts_i.scan_end) begin
      case (req_i)
        romt_pkg::ReqRemove: if (!sts_i.id_zero && (found_q || sts_i.hit)) begin
          cmd_o.drop_prev = 1'b1;
          cmd_o.bump_rev = 1'b1;
        end
        romt_pkg::ReqMarkRead: if (!sts_i.id_zero && (found_q || sts_i.hit)) begin
          cmd_o.drop_prev = 1'b1;
        end
        default: ;
      endcase
    end
    if (state_q == Decode) begin
      case (req_i)
        romt_pkg::ReqClear: if (!sts_i.empty) begin
          cmd_o.clear_all = 1'b1;
          cmd_o.bump_rev = 1'b1;
        end
        romt_pkg::ReqPreview: cmd_o.take_prev = 1'b1;
        default: ;
      endcase
    end
    if (state_q == Shift && sts_i.at_end) begin
      if (req_i == romt_pkg::ReqRemove) cmd_o.dec_fill = 1'b1;
    end
    if (state_q == Write) begin
      cmd_o.bump_rev = 1'b1;
      cmd_o.set_prev = !sts_i.dnd;
      cmd_o.inc_fill = !found_q && !sts_i.full;
    end
    if (state_q == CntStart && req_i == romt_pkg::ReqMarkRead && mov_q) begin
      cmd_o.clr_unread = sts_i.found_unread;
      cmd_o.bump_rev = sts_i.found_unread;
    end
    // pointer steering between phases
    if (state_q == Search && sts_i.scan_end) begin
      if ((found_q || sts_i.hit) && (req_i == romt_pkg::ReqRemove ||
          req_i == romt_pkg::ReqUpsert)) cmd_o.ptr_found = 1'b1;
      // new entry on a full table: evict from slot 0
      else if (req_i == romt_pkg::ReqUpsert && sts_i.full) cmd_o.ptr_zero = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      found_q <= 1'b0;
      mov_q <= 1'b0;
      st_q <= romt_pkg::StOk;
      al_q <= 1'b0;
      lk_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      case (state_q)
        Idle: if (in_valid_i) begin
          state_q <= Decode;
          found_q <= 1'b0;
          mov_q <= 1'b0;
          st_q <= romt_pkg::StOk;
          al_q <= 1'b0;
          lk_q <= 1'b0;
        end
        Decode: begin
          case (req_i)
            romt_pkg::ReqUpsert: begin
              if (!sts_i.req_ok) begin
                st_q <= romt_pkg::StInvalid;
                state_q <= CntStart;
              end else if (sts_i.empty) begin
                state_q <= Write;
              end else state_q <= Search;
            end
            romt_pkg::ReqRemove, romt_pkg::ReqMarkRead, romt_pkg::ReqLookup: begin
              if (sts_i.id_zero) begin
                st_q <= romt_pkg::StInvalid;
                state_q <= CntStart;
              end else if (sts_i.empty) begin
                st_q <= romt_pkg::StNotFound;
                state_q <= CntStart;
              end else state_q <= Search;
            end
            romt_pkg::ReqClear, romt_pkg::ReqPreview: state_q <= CntStart;
            default: begin
              st_q <= romt_pkg::StInvalid;
              state_q <= CntStart;
            end
          endcase
        end
        Search: begin
          if (sts_i.hit) found_q <= 1'b1;
          if (sts_i.scan_end) begin
            case (req_i)
              romt_pkg::ReqUpsert: state_q <= Shift;
              romt_pkg::ReqRemove: begin
                if (found_q || sts_i.hit) state_q <= Shift;
                else begin
                  st_q <= romt_pkg::StNotFound;
                  state_q <= CntStart;
                end
              end
              default: begin
                if (found_q || sts_i.hit) begin
                  mov_q <= 1'b1;
                  lk_q <= (req_i == romt_pkg::ReqLookup);
                end else st_q <= romt_pkg::StNotFound;
                state_q <= CntStart;
              end
            endcase
          end
        end
        Shift: begin
          // upsert decisions made on first shift cycle
          if (req_i == romt_pkg::ReqUpsert && !mov_q) begin
            mov_q <= 1'b1;
            if (found_q && sts_i.same) state_q <= CntStart;
            else if (!found_q && !sts_i.full) state_q <= Write;
          end
          if (sts_i.at_end && state_q == Shift &&
              !(req_i == romt_pkg::ReqUpsert && !mov_q &&
                ((found_q && sts_i.same) || (!found_q && !sts_i.full)))) begin
            if (req_i == romt_pkg::ReqUpsert) state_q <= Write;
            else state_q <= CntStart;
          end
        end
        Write: begin
          al_q <= !sts_i.dnd;
          state_q <= CntStart;
        end
        CntStart: state_q <= Count;
        Count: if (sts_i.cnt_end) begin
          state_q <= Done;
          out_v_q <= 1'b1;
        end
        Done: if (!out_v_q || out_ready_i) state_q <= Idle;
        default: state_q <= Idle;
      endcase
    end
  end
endmodule

### rtl/recency_ordered_message_table_unit.sv
// top level of the recency ordered message table
// depends on romt_pkg, romt_ctrl, romt_datapath
//
// channel   dir  signals                        contents
// s_axis    in   s_axis_tvalid/tready/tdata     request item, 112 bits
// m_axis    out  m_axis_tvalid/tready/tdata     result item, 112 bits
// cfg       in   cfg_we_i/cfg_idx_i/cfg_data_i  register write
//
// the time from accept to the next accept is set by the one-slot-per-cycle key
// search, the slot shift and the unread count sweep.
// reset clears counters, revision and pending preview; slots are not cleared.
// the next item is taken once the result has been handed over.
module recency_ordered_message_table_unit #(
  parameter int unsigned MaxEntries = romt_pkg::MaxEntries
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type, msg_id, app_code, hour_of_day, minute_of_hour, title_length,
  // body_length, content_tag
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, alert, item_count, unread_count, revision, preview_id, entry_app,
  // entry_hour, entry_minute, entry_unread, entry_title_len, entry_body_len
  output logic [111:0] m_axis_tdata
);
  romt_pkg::romt_cmd_t cmd;
  romt_pkg::romt_sts_t sts;
  logic [2:0] req;

  romt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .req_i(req), .sts_i(sts), .cmd_o(cmd)
  );

  romt_datapath #(.MaxEntries(MaxEntries)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_data_i(s_axis_tdata), .cmd_i(cmd), .sts_o(sts), .req_o(req),
    .res_o(m_axis_tdata)
  );

  a_cnt_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10:7] <= m_axis_tdata[6:3]))
    else $error("unread count above fill");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("item accepted while result pending");
  a_alert_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[1:0] == romt_pkg::StOk))
    else $error("alert on failed request");
endmodule
